FILE: sv/rfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcs_pkg
// Shared types, widths and codes for the RSSI free channel scan core.
// ----------------------------------------------------------------------------
package rfcs_pkg;

  localparam int MAX_CHANNELS_DEF = 16;

  localparam int RssiW    = 9;
  localparam int WinW     = 16;
  localparam int NeedW    = 16;
  localparam int LimitW   = 20;
  localparam int ChCntW   = 5;
  localparam int SettleW  = 8;
  localparam int ChIdxW   = 4;
  localparam int StateW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_RSSI_THRESHOLD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_SAMPLES = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NEEDED_WINDOWS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCAN_LIMIT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_SAMPLES = 3'd5;

  // reported scan state
  localparam logic [StateW-1:0] SCAN_IDLE  = 2'd0;
  localparam logic [StateW-1:0] SCAN_BUSY  = 2'd1;
  localparam logic [StateW-1:0] SCAN_FOUND = 2'd2;
  localparam logic [StateW-1:0] SCAN_NONE  = 2'd3;

  // input function codes
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_SENSE  = 3'd2,
    PH_FOUND  = 3'd3,
    PH_NONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic signed [RssiW-1:0] rssi_threshold;
    logic [WinW-1:0]         window_samples;
    logic [NeedW-1:0]        needed_windows;
    logic [LimitW-1:0]       scan_limit;
    logic [ChCntW-1:0]       channel_count;
    logic [SettleW-1:0]      settle_samples;
  } rfcs_cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [ChIdxW-1:0]   chan;
    logic [NeedW-1:0]    free_run;
    logic [WinW-1:0]     win_cnt;
    logic [SettleW-1:0]  settle_cnt;
    logic [LimitW-1:0]   elapsed;
  } rfcs_state_t;

  typedef struct packed {
    logic [StateW-1:0] scan_state;
    logic [ChIdxW-1:0] channel_index;
    logic              retune;
    logic              window_busy;
    logic [NeedW-1:0]  free_windows;
  } rfcs_res_t;

endpackage

FILE: sv/rfcs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcs_step
// Next-state and result logic for one command or sample word.
// ----------------------------------------------------------------------------
module rfcs_step #(
  parameter int MAX_CHANNELS = rfcs_pkg::MAX_CHANNELS_DEF
) (
  input  rfcs_pkg::rfcs_cfg_t            cfg,
  input  rfcs_pkg::rfcs_state_t          st,
  input  logic                           func,
  input  logic signed [rfcs_pkg::RssiW-1:0] rssi,
  output rfcs_pkg::rfcs_state_t          st_nxt,
  output rfcs_pkg::rfcs_res_t            res
);
  import rfcs_pkg::*;

  localparam int MaxW = $clog2(MAX_CHANNELS + 1);
  localparam int CntW = (MaxW > ChCntW) ? MaxW : ChCntW;

  logic [CntW-1:0]   ch_lim;
  logic [CntW-1:0]   ch_inc;
  logic [ChIdxW-1:0] ch_next;
  logic [WinW-1:0]   win_len;
  logic              retune;
  logic              busy;

  // wrap point of the channel list and the channel after the current one
  always_comb begin
    if (CntW'(cfg.channel_count) > CntW'(MAX_CHANNELS)) begin
      ch_lim = CntW'(MAX_CHANNELS);
    end else begin
      ch_lim = CntW'(cfg.channel_count);
    end
    ch_inc = CntW'(st.chan) + CntW'(1);
    if (ch_lim == '0 || ch_inc >= ch_lim) begin
      ch_next = '0;
    end else begin
      ch_next = ch_inc[ChIdxW-1:0];
    end
    win_len = (cfg.window_samples == '0) ? WinW'(1) : cfg.window_samples;
  end

  // next state
  always_comb begin
    logic ended;
    ended  = 1'b0;
    st_nxt = st;
    retune = 1'b0;
    busy   = 1'b0;
    if (func == FUNC_START) begin
      st_nxt.chan       = '0;
      st_nxt.free_run   = '0;
      st_nxt.elapsed    = '0;
      st_nxt.settle_cnt = '0;
      st_nxt.win_cnt    = '0;
      st_nxt.phase      = (cfg.settle_samples == '0) ? PH_SENSE : PH_SETTLE;
      retune            = 1'b1;
    end else if (st.phase == PH_SETTLE || st.phase == PH_SENSE) begin
      if (st.elapsed != '1) begin
        st_nxt.elapsed = st.elapsed + LimitW'(1);
      end
      if (st.phase == PH_SETTLE) begin
        st_nxt.settle_cnt = st.settle_cnt + SettleW'(1);
        if (st_nxt.settle_cnt >= cfg.settle_samples) begin
          st_nxt.phase   = PH_SENSE;
          st_nxt.win_cnt = '0;
        end
      end else begin
        st_nxt.win_cnt = st.win_cnt + WinW'(1);
        if (rssi > cfg.rssi_threshold) begin
          busy            = 1'b1;
          st_nxt.free_run = '0;
          st_nxt.chan     = ch_next;
          retune          = 1'b1;
          ended           = 1'b1;
        end else if (st_nxt.win_cnt >= win_len) begin
          if (st.free_run != '1) begin
            st_nxt.free_run = st.free_run + NeedW'(1);
          end
          if (st_nxt.free_run >= cfg.needed_windows) begin
            st_nxt.phase = PH_FOUND;
          end else begin
            ended = 1'b1;
          end
        end
      end
      if (ended) begin
        if (st_nxt.elapsed > cfg.scan_limit) begin
          st_nxt.phase = PH_NONE;
          retune       = 1'b0;
        end else begin
          st_nxt.settle_cnt = '0;
          st_nxt.win_cnt    = '0;
          st_nxt.phase      = (cfg.settle_samples == '0) ? PH_SENSE : PH_SETTLE;
        end
      end
    end
  end

  // result word
  always_comb begin
    res.channel_index = st_nxt.chan;
    res.retune        = retune;
    res.window_busy   = busy;
    res.free_windows  = st_nxt.free_run;
    case (st_nxt.phase)
      PH_IDLE:  res.scan_state = SCAN_IDLE;
      PH_FOUND: res.scan_state = SCAN_FOUND;
      PH_NONE:  res.scan_state = SCAN_NONE;
      default:  res.scan_state = SCAN_BUSY;
    endcase
  end

endmodule

FILE: sv/rssi_free_channel_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_free_channel_scan_core
// Listen-before-talk scan over a list of channels for one that stays quiet.
// ----------------------------------------------------------------------------
//  port group | direction | handshake             | payload
//  in_        | input     | in_valid / in_stall   | in_func, in_rssi
//  out_       | output    | out_valid / out_stall | out_scan_state, out_channel_index,
//             |           |                       | out_retune, out_window_busy,
//             |           |                       | out_free_windows
//  cfg_       | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word a cycle sustained while out_stall stays low; each word passes from
// in_ to out_ through the input register, then through the step logic into the
// result register. The scan state updates when a word moves into the result register.
// Reset (rst_n low, synchronous) empties both registers, returns the scan to
// idle and loads the register defaults. A stalled result holds the input
// register full, and in_stall rises only then; cfg_ready is always high.
// ----------------------------------------------------------------------------
module rssi_free_channel_scan_core #(
  parameter int MAX_CHANNELS = rfcs_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [rfcs_pkg::RssiW-1:0]   in_rssi,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rfcs_pkg::StateW-1:0]         out_scan_state,
  output logic [rfcs_pkg::ChIdxW-1:0]         out_channel_index,
  output logic                                out_retune,
  output logic                                out_window_busy,
  output logic [rfcs_pkg::NeedW-1:0]          out_free_windows,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rfcs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [rfcs_pkg::CfgDataW-1:0]       cfg_data
);
  import rfcs_pkg::*;

  rfcs_cfg_t   cfg_r;
  rfcs_state_t st_r;
  rfcs_state_t st_nxt;
  rfcs_res_t   res_nxt;
  rfcs_res_t   res_r;

  logic                    in_valid_r;
  logic                    func_r;
  logic signed [RssiW-1:0] rssi_r;
  logic                    out_valid_r;
  logic                    advance;
  logic                    in_take;

  // the result register frees up when empty or when its word is taken
  assign advance  = ~out_valid_r | ~out_stall;
  assign in_stall = in_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rssi_threshold <= -9'sd90;
      cfg_r.window_samples <= WinW'(5);
      cfg_r.needed_windows <= NeedW'(100);
      cfg_r.scan_limit     <= LimitW'(3000);
      cfg_r.channel_count  <= ChCntW'(8);
      cfg_r.settle_samples <= SettleW'(4);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RSSI_THRESHOLD: cfg_r.rssi_threshold <= cfg_data[RssiW-1:0];
        REG_WINDOW_SAMPLES: cfg_r.window_samples <= cfg_data[WinW-1:0];
        REG_NEEDED_WINDOWS: cfg_r.needed_windows <= cfg_data[NeedW-1:0];
        REG_SCAN_LIMIT:     cfg_r.scan_limit     <= cfg_data[LimitW-1:0];
        REG_CHANNEL_COUNT:  cfg_r.channel_count  <= cfg_data[ChCntW-1:0];
        REG_SETTLE_SAMPLES: cfg_r.settle_samples <= cfg_data[SettleW-1:0];
        default: ;
      endcase
    end
  end

  // input register: hold the word while the result side is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_func;
      rssi_r <= in_rssi;
    end
  end

  rfcs_step #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .func   (func_r),
    .rssi   (rssi_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // scan state advances only as a word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_IDLE;
      st_r.chan       <= '0;
      st_r.free_run   <= '0;
      st_r.win_cnt    <= '0;
      st_r.settle_cnt <= '0;
      st_r.elapsed    <= '0;
    end else if (in_valid_r && advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scan_state    = res_r.scan_state;
  assign out_channel_index = res_r.channel_index;
  assign out_retune        = res_r.retune;
  assign out_window_busy   = res_r.window_busy;
  assign out_free_windows  = res_r.free_windows;

endmodule

FILE: sv/rfcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcs_checker
// Port-level checks on the scan core, bound to the top level.
// ----------------------------------------------------------------------------
module rfcs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rfcs_pkg::StateW-1:0] out_scan_state,
  input logic [rfcs_pkg::ChIdxW-1:0] out_channel_index,
  input logic                        out_retune,
  input logic                        out_window_busy,
  input logic [rfcs_pkg::NeedW-1:0]  out_free_windows
);
  import rfcs_pkg::*;

  // a busy end clears the run and leaves the scan running or given up
  a_busy_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_busy |->
      out_free_windows == '0 &&
      (out_scan_state == SCAN_BUSY || out_scan_state == SCAN_NONE))
    else $error("busy end with run kept or wrong state");

  // retune only while scanning; a retune without busy is a fresh start
  a_retune_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_retune |-> out_scan_state == SCAN_BUSY &&
      (out_window_busy || (out_channel_index == '0 && out_free_windows == '0)))
    else $error("retune outside a scan or start not on channel zero");

  // idle means no scan was ever started
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scan_state == SCAN_IDLE |->
      !out_retune && !out_window_busy && out_channel_index == '0 &&
      out_free_windows == '0)
    else $error("idle result carries scan data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scan_state) &&
      $stable(out_channel_index) && $stable(out_retune) &&
      $stable(out_window_busy) && $stable(out_free_windows))
    else $error("stalled result word changed");

endmodule

bind rssi_free_channel_scan_core rfcs_checker u_rfcs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_scan_state    (out_scan_state),
  .out_channel_index (out_channel_index),
  .out_retune        (out_retune),
  .out_window_busy   (out_window_busy),
  .out_free_windows  (out_free_windows)
);

FILE: tb/rfcs_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcs_scan_checker
// Follows the word, result and register channels of the scan core. Keeps its
// own copy of the scan state and settings, predicts one report per accepted
// word and compares the reports in order, field by field.
// ----------------------------------------------------------------------------
module rfcs_scan_checker #(
  parameter int MAX_CHANNELS = rfcs_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [rfcs_pkg::RssiW-1:0] in_rssi,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [rfcs_pkg::StateW-1:0]       out_scan_state,
  input  logic [rfcs_pkg::ChIdxW-1:0]       out_channel_index,
  input  logic                              out_retune,
  input  logic                              out_window_busy,
  input  logic [rfcs_pkg::NeedW-1:0]        out_free_windows,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rfcs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [rfcs_pkg::CfgDataW-1:0]     cfg_data,
  output int unsigned                       fail_count,
  output int unsigned                       pending,
  output int unsigned                       live_words,
  output logic                              scan_open
);
  import rfcs_pkg::*;

  rfcs_cfg_t   settings;
  rfcs_state_t scan;
  rfcs_res_t   report_q[$];

  // start a fresh window: settle first unless no settling is asked for
  function automatic void reopen_window();
    scan.settle_cnt = '0;
    scan.win_cnt    = '0;
    if (settings.settle_samples == 0) begin
      scan.phase = PH_SENSE;
    end else begin
      scan.phase = PH_SETTLE;
    end
  endfunction

  function automatic rfcs_res_t predict_report(input logic func,
                                               input logic signed [RssiW-1:0] rssi);
    rfcs_res_t               res;
    logic signed [RssiW-1:0] thr;
    logic                    ended;
    int                      span;
    int                      lim;
    res   = '0;
    thr   = settings.rssi_threshold;
    ended = 1'b0;
    if (func == FUNC_START) begin
      scan.chan     = '0;
      scan.free_run = '0;
      scan.elapsed  = '0;
      reopen_window();
      res.retune    = 1'b1;
    end else if (scan.phase == PH_SETTLE || scan.phase == PH_SENSE) begin
      if (scan.elapsed != '1) scan.elapsed = scan.elapsed + 1'b1;
      if (scan.phase == PH_SETTLE) begin
        scan.settle_cnt = scan.settle_cnt + 1'b1;
        if (scan.settle_cnt >= settings.settle_samples) begin
          scan.phase   = PH_SENSE;
          scan.win_cnt = '0;
        end
      end else begin
        span = (settings.window_samples == 0) ? 1 : int'(settings.window_samples);
        scan.win_cnt = scan.win_cnt + 1'b1;
        if (rssi > thr) begin
          res.window_busy = 1'b1;
          res.retune      = 1'b1;
          scan.free_run   = '0;
          lim = (settings.channel_count > MAX_CHANNELS) ? MAX_CHANNELS
                                                        : int'(settings.channel_count);
          if (lim == 0 || int'(scan.chan) + 1 >= lim) begin
            scan.chan = '0;
          end else begin
            scan.chan = scan.chan + 1'b1;
          end
          ended = 1'b1;
        end else if (int'(scan.win_cnt) >= span) begin
          if (scan.free_run != '1) scan.free_run = scan.free_run + 1'b1;
          if (scan.free_run >= settings.needed_windows) begin
            scan.phase = PH_FOUND;
          end else begin
            ended = 1'b1;
          end
        end
      end
      // time check at the window boundary; a find already took priority
      if (ended) begin
        if (scan.elapsed > settings.scan_limit) begin
          scan.phase = PH_NONE;
          res.retune = 1'b0;
        end else begin
          reopen_window();
        end
      end
    end
    case (scan.phase)
      PH_IDLE:  res.scan_state = SCAN_IDLE;
      PH_FOUND: res.scan_state = SCAN_FOUND;
      PH_NONE:  res.scan_state = SCAN_NONE;
      default:  res.scan_state = SCAN_BUSY;
    endcase
    res.channel_index = scan.chan;
    res.free_windows  = scan.free_run;
    return res;
  endfunction

  always @(posedge clk) begin
    rfcs_res_t want;
    if (!rst_n) begin
      settings.rssi_threshold = -9'sd90;
      settings.window_samples = 16'd5;
      settings.needed_windows = 16'd100;
      settings.scan_limit     = 20'd3000;
      settings.channel_count  = 5'd8;
      settings.settle_samples = 8'd4;
      scan       = '0;
      scan.phase = PH_IDLE;
      report_q.delete();
      fail_count = 0;
      live_words = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RSSI_THRESHOLD: settings.rssi_threshold = cfg_data[RssiW-1:0];
          REG_WINDOW_SAMPLES: settings.window_samples = cfg_data[WinW-1:0];
          REG_NEEDED_WINDOWS: settings.needed_windows = cfg_data[NeedW-1:0];
          REG_SCAN_LIMIT:     settings.scan_limit     = cfg_data[LimitW-1:0];
          REG_CHANNEL_COUNT:  settings.channel_count  = cfg_data[ChCntW-1:0];
          REG_SETTLE_SAMPLES: settings.settle_samples = cfg_data[SettleW-1:0];
          default: ;
        endcase
      end
      // compare before queueing: a word accepted now cannot leave this edge
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("report arrived with no prediction waiting");
          fail_count++;
        end else begin
          want = report_q.pop_front();
          if (out_scan_state !== want.scan_state) begin
            $error("scan_state: expected %0d, got %0d", want.scan_state, out_scan_state);
            fail_count++;
          end
          if (out_channel_index !== want.channel_index) begin
            $error("channel_index: expected %0d, got %0d",
                   want.channel_index, out_channel_index);
            fail_count++;
          end
          if (out_retune !== want.retune) begin
            $error("retune: expected %0d, got %0d", want.retune, out_retune);
            fail_count++;
          end
          if (out_window_busy !== want.window_busy) begin
            $error("window_busy: expected %0d, got %0d", want.window_busy, out_window_busy);
            fail_count++;
          end
          if (out_free_windows !== want.free_windows) begin
            $error("free_windows: expected %0d, got %0d",
                   want.free_windows, out_free_windows);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_START || scan.phase == PH_SETTLE || scan.phase == PH_SENSE)
          live_words++;
        report_q.push_back(predict_report(in_func, in_rssi));
      end
    end
    pending   = report_q.size();
    scan_open = (scan.phase == PH_SETTLE || scan.phase == PH_SENSE);
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the RSSI free channel scan core with start and sample words under
// changing register settings: a short directed run through the corner cases,
// then random scans shaped to reach found, busy hops and give-ups. Results
// are checked by the scan checker; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import rfcs_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int RANDOM_WORDS = 650;   // live words in the random part

  // indexes past the end of the register list; writes there must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_func;
  logic signed [RssiW-1:0] in_rssi;
  logic                  out_valid;
  logic                  out_stall;
  logic [StateW-1:0]     out_scan_state;
  logic [ChIdxW-1:0]     out_channel_index;
  logic                  out_retune;
  logic                  out_window_busy;
  logic [NeedW-1:0]      out_free_windows;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxW-1:0]    cfg_index;
  logic [CfgDataW-1:0]   cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned live_words;
  logic        scan_open;

  // per-phase switches for the random gaps on each side
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  // threshold last written, so sample levels can be aimed either side of it
  int cur_thr = -90;

  always #6 clk = ~clk;

  rssi_free_channel_scan_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_rssi           (in_rssi),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scan_state    (out_scan_state),
    .out_channel_index (out_channel_index),
    .out_retune        (out_retune),
    .out_window_busy   (out_window_busy),
    .out_free_windows  (out_free_windows),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  rfcs_scan_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_rssi           (in_rssi),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scan_state    (out_scan_state),
    .out_channel_index (out_channel_index),
    .out_retune        (out_retune),
    .out_window_busy   (out_window_busy),
    .out_free_windows  (out_free_windows),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .live_words        (live_words),
    .scan_open         (scan_open)
  );

  // Offer one word after a random gap, hold it until taken, then drop valid.
  // Called at a falling edge and returns at one.
  task automatic push_word(input logic func, input logic signed [RssiW-1:0] rssi);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    in_func  = func;
    in_rssi  = rssi;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Write the whole register set; only call with nothing in flight.
  task automatic load_settings(input int thr, input int win, input int need,
                               input int lim, input int chans, input int settle);
    write_reg(REG_RSSI_THRESHOLD, CfgDataW'(thr));
    write_reg(REG_WINDOW_SAMPLES, CfgDataW'(win));
    write_reg(REG_NEEDED_WINDOWS, CfgDataW'(need));
    write_reg(REG_SCAN_LIMIT,     CfgDataW'(lim));
    write_reg(REG_CHANNEL_COUNT,  CfgDataW'(chans));
    write_reg(REG_SETTLE_SAMPLES, CfgDataW'(settle));
    cur_thr = thr;
  endtask

  // Every word yields a report, so an empty prediction store means idle.
  task automatic drain_results();
    while (pending != 0) @(negedge clk);
  endtask

  // Pick a sample level: above the threshold with the given odds, at or
  // below it otherwise, and now and then anything the 9-bit field holds.
  function automatic logic signed [RssiW-1:0] draw_rssi(input int busy_pct);
    int lo;
    int hi;
    int v;
    if ($urandom_range(0, 19) == 0) return RssiW'($urandom_range(0, 511));
    lo = (cur_thr > -160) ? -160 : -256;
    hi = (cur_thr < 0) ? 0 : 255;
    if (cur_thr < hi && $urandom_range(0, 99) < busy_pct) begin
      v = cur_thr + 1 + $urandom_range(0, hi - cur_thr - 1);
    end else begin
      v = lo + $urandom_range(0, cur_thr - lo);
    end
    return RssiW'(v);
  endfunction

  // Result side: stall for a random count before each report, then take it.
  initial begin : result_taker
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = rx_idle ? $urandom_range(0, 3) : 0;
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Watchdog: give up once no channel has moved a word for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int thr;
    int win;
    int need;
    int lim;
    int chans;
    int settle;
    int busy_pct;
    int span;
    int phase_no;
    int unsigned base;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FUNC_START;
    in_rssi   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RSSI_THRESHOLD;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: one-tick windows, three channels, no settling
    load_settings(-90, 1, 2, 20'hFFFFF, 3, 0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 20'h5A5A5);
    push_word(FUNC_SAMPLE, 9'sd0);        // idle: sample dropped
    push_word(FUNC_START, 9'h100);
    push_word(FUNC_SAMPLE, -9'sd160);     // quiet window, run of one
    push_word(FUNC_SAMPLE, 9'sd0);        // busy, hop to channel 1
    push_word(FUNC_SAMPLE, -9'sd90);      // level equal to threshold is quiet
    push_word(FUNC_SAMPLE, -9'sd89);      // busy, channel 2
    push_word(FUNC_SAMPLE, -9'sd1);       // busy, wrap back to channel 0
    push_word(FUNC_SAMPLE, -9'sd160);
    push_word(FUNC_START, 9'h0FF);        // restart mid-scan
    push_word(FUNC_SAMPLE, -9'sd100);
    push_word(FUNC_SAMPLE, -9'sd100);     // second quiet window: found
    push_word(FUNC_SAMPLE, 9'sd255);      // dropped once found
    drain_results();

    // zero window length, zero needed count, zero limit, one channel
    load_settings(-90, 0, 0, 0, 1, 2);
    push_word(FUNC_START, 9'h000);
    push_word(FUNC_SAMPLE, 9'sd0);        // settle ticks ignore the level
    push_word(FUNC_SAMPLE, 9'sd0);
    push_word(FUNC_SAMPLE, 9'h100);       // found wins over the time check
    push_word(FUNC_START, 9'h1FF);
    push_word(FUNC_SAMPLE, 9'sd0);
    push_word(FUNC_SAMPLE, 9'sd0);
    push_word(FUNC_SAMPLE, 9'sd0);        // busy and out of time: give up
    push_word(FUNC_SAMPLE, -9'sd100);     // dropped after give-up
    drain_results();

    // threshold zero, empty channel list
    load_settings(0, 2, 3, 20'hFFFFF, 0, 0);
    push_word(FUNC_START, 9'h0AA);
    push_word(FUNC_SAMPLE, 9'sd255);      // busy, channel stays 0, retune still up
    push_word(FUNC_SAMPLE, 9'sd0);
    push_word(FUNC_SAMPLE, -9'sd1);       // quiet window ends

    // --- random scans, each under fresh settings
    drain_results();
    base     = live_words;
    phase_no = 0;
    while (live_words - base < RANDOM_WORDS) begin
      drain_results();
      if (phase_no == 0) begin
        // busy-heavy run over an oversized list to reach the channel wrap
        thr = -90; win = 1; need = 16'hFFFF; lim = 20'hFFFFF; chans = 31; settle = 0;
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          thr = $signed(RssiW'($urandom_range(0, 511)));
        end else begin
          case ($urandom_range(0, 9))
            0:       thr = -160;
            1:       thr = 0;
            default: thr = -160 + int'($urandom_range(0, 160));
          endcase
        end
        case ($urandom_range(0, 9))
          0:       win = 16'hFFFF;
          1:       win = 0;
          default: win = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 9))
          0:       need = 16'hFFFF;
          1:       need = 0;
          default: need = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 7))
          0:       lim = 0;
          1:       lim = 20'hFFFFF;
          2:       lim = $urandom_range(0, 20'hFFFFF);
          default: lim = $urandom_range(10, 400);
        endcase
        case ($urandom_range(0, 9))
          0:       chans = 0;
          1:       chans = $urandom_range(17, 31);
          2:       chans = 16;
          default: chans = $urandom_range(1, 8);
        endcase
        settle = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3);
      end
      load_settings(thr, win, need, lim, chans, settle);

      // each side runs flat out in a third of the phases
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_idle = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 3))
        0:       busy_pct = 5;
        1:       busy_pct = 15;
        2:       busy_pct = 35;
        default: busy_pct = 70;
      endcase
      if (phase_no == 0) busy_pct = 90;

      span = $urandom_range(20, 60);
      push_word(FUNC_START, RssiW'($urandom_range(0, 511)));
      repeat (span) begin
        // now and then hold the sender until every report is home
        if ($urandom_range(0, 39) == 0) drain_results();
        // restart soon after a scan ends, and rarely in the middle of one
        if ((!scan_open && $urandom_range(0, 3) != 0) || $urandom_range(0, 29) == 0)
          push_word(FUNC_START, RssiW'($urandom_range(0, 511)));
        else
          push_word(FUNC_SAMPLE, draw_rssi(busy_pct));
      end
      phase_no++;
    end

    // wait out the two-stage pipe, then give the verdict
    drain_results();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
